// File: rtl/apcm_pkg.sv
`timescale 1ns / 1ps

package apcm_pkg;

    // Sample and result widths.
    localparam int MAG_W      = 24;
    localparam int SQR_W      = 2 * MAG_W - 1;
    localparam int RMS_W      = 24;
    localparam int LEVEL_W    = 31;
    localparam int PROD_W     = 48;
    localparam int ACC_W      = PROD_W + 1;
    localparam int CMP_W      = 37;
    localparam int DEB_W      = 10;
    localparam int CLIP_CNT_W = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_LEVEL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ON_DEBOUNCE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_DEBOUNCE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEVEL      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_CHUNK_LIMIT = 3'd4;

    localparam logic [22:0]           PRESENCE_LEVEL_RST = 23'd838;
    localparam logic [DEB_W-1:0]      ON_DEBOUNCE_RST    = 10'd120;
    localparam logic [DEB_W-1:0]      OFF_DEBOUNCE_RST   = 10'd100;
    localparam logic [MAG_W-1:0]      CLIP_LEVEL_RST     = 24'd8388000;
    localparam logic [CLIP_CNT_W-1:0] CLIP_LIMIT_RST     = 16'd25;

    // Smoothing filter, Q16 weights.
    localparam logic [15:0] ALPHA_Q16  = 16'd3277;
    localparam logic [15:0] KEEP_Q16   = 16'd62259;
    localparam logic [15:0] ROUND_HALF = 16'd32768;

    localparam logic [LEVEL_W-1:0]    LEVEL_MAX    = {LEVEL_W{1'b1}};
    localparam logic [CLIP_CNT_W-1:0] CLIP_CNT_MAX = {CLIP_CNT_W{1'b1}};
    localparam logic [DEB_W-1:0]      DEB_MAX      = {DEB_W{1'b1}};

    // Default chunk geometry and the widths that follow from it.
    localparam int MAX_CHUNK_FRAMES_DEF = 256;
    localparam int PICK_STRIDE_DEF      = 8;
    localparam int PICK_MAX_DEF = (MAX_CHUNK_FRAMES_DEF + PICK_STRIDE_DEF - 1) / PICK_STRIDE_DEF;
    localparam int CNT_W_DEF    = $clog2(PICK_MAX_DEF + 1);
    localparam int SUM_W_DEF    = SQR_W + CNT_W_DEF + ((SQR_W + CNT_W_DEF) % 2);

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b0000000001,
        ST_FRAME   = 10'b0000000010,
        ST_ACCUM   = 10'b0000000100,
        ST_DIV     = 10'b0000001000,
        ST_SQRT    = 10'b0000010000,
        ST_EMA_A   = 10'b0000100000,
        ST_EMA_B   = 10'b0001000000,
        ST_EMA_SUM = 10'b0010000000,
        ST_DECIDE  = 10'b0100000000,
        ST_EMIT    = 10'b1000000000
    } state_t;

    typedef struct packed {
        logic take_frame;
        logic frame_step;
        logic accum;
        logic div_init;
        logic div_step;
        logic sqrt_step;
        logic ema_a;
        logic ema_b;
        logic ema_sum;
        logic decide;
        logic chunk_clear;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic last;
    } status_t;

endpackage

// File: rtl/audio_presence_and_clip_monitor_core.sv
`timescale 1ns / 1ps
// A frame that does not end its chunk passes through the FRAME and ACCUM states;
// s_ready returns after that. A chunk-end frame then runs the bit-serial divider
// and square root, the smoothing and decision states before its status is presented.
// A new frame is taken only once the previous one is done and s_ready is back high;
// a chunk-end frame takes longer while the previous status request is still waiting.
// Reset: synchronous, active-low aresetn clears all state and loads register defaults.

module audio_presence_and_clip_monitor_core #(
    parameter int MAX_CHUNK_FRAMES = apcm_pkg::MAX_CHUNK_FRAMES_DEF,
    parameter int PICK_STRIDE      = apcm_pkg::PICK_STRIDE_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [apcm_pkg::MAG_W-1:0]   s_left_sample,
    input  logic                                s_chunk_end,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_playing,
    output logic                                m_clipping,
    output logic [apcm_pkg::LEVEL_W-1:0]        m_smoothed_level,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [apcm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [apcm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int PICK_MAX = (MAX_CHUNK_FRAMES + PICK_STRIDE - 1) / PICK_STRIDE;
    localparam int CNT_W    = $clog2(PICK_MAX + 1);
    localparam int SUM_RAW  = apcm_pkg::SQR_W + CNT_W;
    localparam int SUM_W    = SUM_RAW + (SUM_RAW % 2);

    apcm_pkg::cmd_t    cmd;
    apcm_pkg::status_t status;

    apcm_ctrl #(
        .SUM_W (SUM_W)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    apcm_dp #(
        .MAX_CHUNK_FRAMES (MAX_CHUNK_FRAMES),
        .PICK_STRIDE      (PICK_STRIDE),
        .CNT_W            (CNT_W),
        .SUM_W            (SUM_W)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_left_sample    (s_left_sample),
        .s_chunk_end      (s_chunk_end),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_playing        (m_playing),
        .m_clipping       (m_clipping),
        .m_smoothed_level (m_smoothed_level)
    );

endmodule

// File: rtl/apcm_dp.sv
`timescale 1ns / 1ps

module apcm_dp #(
    parameter int MAX_CHUNK_FRAMES = apcm_pkg::MAX_CHUNK_FRAMES_DEF,
    parameter int PICK_STRIDE      = apcm_pkg::PICK_STRIDE_DEF,
    parameter int CNT_W            = apcm_pkg::CNT_W_DEF,
    parameter int SUM_W            = apcm_pkg::SUM_W_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  apcm_pkg::cmd_t                         cmd,
    output apcm_pkg::status_t                      status,
    input  logic signed [apcm_pkg::MAG_W-1:0]      s_left_sample,
    input  logic                                   s_chunk_end,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [apcm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [apcm_pkg::CFG_DATA_W-1:0]        cfg_data,
    output logic                                   m_playing,
    output logic                                   m_clipping,
    output logic [apcm_pkg::LEVEL_W-1:0]           m_smoothed_level
);

    localparam int MAG_W      = apcm_pkg::MAG_W;
    localparam int SQR_W      = apcm_pkg::SQR_W;
    localparam int RMS_W      = apcm_pkg::RMS_W;
    localparam int LEVEL_W    = apcm_pkg::LEVEL_W;
    localparam int PROD_W     = apcm_pkg::PROD_W;
    localparam int ACC_W      = apcm_pkg::ACC_W;
    localparam int CMP_W      = apcm_pkg::CMP_W;
    localparam int DEB_W      = apcm_pkg::DEB_W;
    localparam int CLIP_CNT_W = apcm_pkg::CLIP_CNT_W;
    localparam int ROOT_W     = SUM_W / 2;
    localparam int POS_W      = $clog2(MAX_CHUNK_FRAMES + 1);
    localparam int PHASE_W    = (PICK_STRIDE > 1) ? $clog2(PICK_STRIDE) : 1;

    // Configuration registers.
    logic [22:0]           presence_reg;
    logic [DEB_W-1:0]      on_deb_reg;
    logic [DEB_W-1:0]      off_deb_reg;
    logic [MAG_W-1:0]      clip_level_reg;
    logic [CLIP_CNT_W-1:0] clip_limit_reg;

    // Chunk accumulation.
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    // Latched frame.
    logic [MAG_W-1:0] mag_reg;
    logic             last_reg;
    logic             pick_reg;
    logic             first_reg;
    logic [SQR_W-1:0] square_reg;

    // Divider and square root.
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [ROOT_W:0]   srem_reg, srem_next;

    // Smoothing and decision.
    logic [PROD_W-1:0]     prod_a_reg;
    logic [PROD_W-1:0]     prod_b_reg;
    logic [LEVEL_W-1:0]    avg_reg, avg_next;
    logic                  playing_reg, playing_next;
    logic                  pending_reg, pending_next;
    logic [DEB_W-1:0]      change_reg, change_next;
    logic [CLIP_CNT_W-1:0] clip_cnt_reg, clip_cnt_next;
    logic                  clip_flag_reg, clip_flag_next;

    logic [MAG_W-1:0]      in_raw;
    logic [MAG_W-1:0]      in_mag;
    logic [2*MAG_W-1:0]    square_full;
    logic [CNT_W:0]        div_shift;
    logic [CNT_W:0]        div_diff;
    logic                  div_ge;
    logic [ROOT_W+2:0]     sq_shift;
    logic [ROOT_W+2:0]     sq_trial;
    logic [ROOT_W+2:0]     sq_diff;
    logic                  sq_ge;
    logic [31:0]           rms_q8;
    logic [ACC_W-1:0]      ema_acc;
    logic [ACC_W-17:0]     ema_q;
    logic [CMP_W-1:0]      avg_w;
    logic [CMP_W-1:0]      lvl_w;
    logic                  enter_hit;
    logic                  exit_hit;
    logic                  candidate;
    logic [DEB_W-1:0]      deb_limit;

    assign cfg_ready = 1'b1;
    assign status.last = last_reg;

    // Two's complement magnitude; the most negative code maps to 2^23.
    assign in_raw = $unsigned(s_left_sample);
    assign in_mag = in_raw[MAG_W-1] ? (~in_raw + MAG_W'(1)) : in_raw;
    assign square_full = mag_reg * mag_reg;

    // One quotient bit per step, the quotient shifts into the sum register.
    assign div_shift = {rem_reg, sum_reg[SUM_W-1]};
    assign div_ge    = div_shift >= {1'b0, count_reg};
    assign div_diff  = div_shift - {1'b0, count_reg};

    // One root bit per step, two radicand bits shift out of the sum register.
    assign sq_shift = {srem_reg, sum_reg[SUM_W-1 -: 2]};
    assign sq_trial = {1'b0, root_reg, 2'b01};
    assign sq_ge    = sq_shift >= sq_trial;
    assign sq_diff  = sq_shift - sq_trial;

    assign rms_q8  = {root_reg[RMS_W-1:0], 8'h00};
    assign ema_acc = ACC_W'(prod_a_reg) + ACC_W'(prod_b_reg) + ACC_W'(apcm_pkg::ROUND_HALF);
    assign ema_q   = ema_acc[ACC_W-1:16];

    // Thresholds scaled by 1.35 and 0.75 in Q8, written as shifts.
    assign avg_w = CMP_W'(avg_reg);
    assign lvl_w = CMP_W'(presence_reg);
    assign enter_hit = ((avg_w << 4) + (avg_w << 2))
                     > ((lvl_w << 12) + (lvl_w << 11) + (lvl_w << 9) + (lvl_w << 8));
    assign exit_hit  = (avg_w << 2) > ((lvl_w << 9) + (lvl_w << 8));
    assign candidate = playing_reg ? exit_hit : enter_hit;
    assign deb_limit = candidate ? on_deb_reg : off_deb_reg;

    always_comb begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        if (cmd.chunk_clear) begin
            pos_next   = '0;
            phase_next = '0;
            sum_next   = '0;
            count_next = '0;
        end else if (cmd.take_frame) begin
            if (pos_reg != POS_W'(MAX_CHUNK_FRAMES)) begin
                pos_next = pos_reg + POS_W'(1);
            end
            if (phase_reg == PHASE_W'(PICK_STRIDE - 1)) begin
                phase_next = '0;
            end else begin
                phase_next = phase_reg + PHASE_W'(1);
            end
        end else if (cmd.accum) begin
            if (pick_reg) begin
                sum_next   = sum_reg + SUM_W'(square_reg);
                count_next = count_reg + CNT_W'(1);
            end
        end else if (cmd.div_step) begin
            sum_next = {sum_reg[SUM_W-2:0], div_ge};
        end else if (cmd.sqrt_step) begin
            sum_next = {sum_reg[SUM_W-3:0], 2'b00};
        end
    end

    always_comb begin
        rem_next  = rem_reg;
        root_next = root_reg;
        srem_next = srem_reg;
        if (cmd.div_init) begin
            rem_next  = '0;
            root_next = '0;
            srem_next = '0;
        end else if (cmd.div_step) begin
            rem_next = div_ge ? div_diff[CNT_W-1:0] : div_shift[CNT_W-1:0];
        end else if (cmd.sqrt_step) begin
            root_next = {root_reg[ROOT_W-2:0], sq_ge};
            srem_next = sq_ge ? sq_diff[ROOT_W:0] : sq_shift[ROOT_W:0];
        end
    end

    always_comb begin
        avg_next = avg_reg;
        if (cmd.ema_sum) begin
            if (ema_q > (ACC_W-16)'(apcm_pkg::LEVEL_MAX)) begin
                avg_next = apcm_pkg::LEVEL_MAX;
            end else begin
                avg_next = ema_q[LEVEL_W-1:0];
            end
        end
    end

    always_comb begin
        playing_next = playing_reg;
        pending_next = pending_reg;
        change_next  = change_reg;
        if (cmd.decide) begin
            if (candidate == playing_reg) begin
                change_next  = '0;
                pending_next = playing_reg;
            end else begin
                if (pending_reg != candidate) begin
                    pending_next = candidate;
                    change_next  = DEB_W'(1);
                end else if (change_reg != apcm_pkg::DEB_MAX) begin
                    change_next = change_reg + DEB_W'(1);
                end
                if (change_next >= deb_limit) begin
                    playing_next = candidate;
                    change_next  = '0;
                end
            end
        end
    end

    // Leaky clip counter, fed by the first frame of each chunk.
    always_comb begin
        clip_cnt_next  = clip_cnt_reg;
        clip_flag_next = clip_flag_reg;
        if (cmd.frame_step && first_reg) begin
            if (mag_reg > clip_level_reg) begin
                if (clip_cnt_reg != apcm_pkg::CLIP_CNT_MAX) begin
                    clip_cnt_next = clip_cnt_reg + CLIP_CNT_W'(1);
                end
            end else if (clip_cnt_reg != '0) begin
                clip_cnt_next = clip_cnt_reg - CLIP_CNT_W'(1);
            end
            if (clip_cnt_next > clip_limit_reg) begin
                clip_flag_next = 1'b1;
            end else if (clip_cnt_next == '0) begin
                clip_flag_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            presence_reg   <= apcm_pkg::PRESENCE_LEVEL_RST;
            on_deb_reg     <= apcm_pkg::ON_DEBOUNCE_RST;
            off_deb_reg    <= apcm_pkg::OFF_DEBOUNCE_RST;
            clip_level_reg <= apcm_pkg::CLIP_LEVEL_RST;
            clip_limit_reg <= apcm_pkg::CLIP_LIMIT_RST;
            pos_reg        <= '0;
            phase_reg      <= '0;
            sum_reg        <= '0;
            count_reg      <= '0;
            last_reg       <= 1'b0;
            avg_reg        <= '0;
            playing_reg    <= 1'b0;
            pending_reg    <= 1'b0;
            change_reg     <= '0;
            clip_cnt_reg   <= '0;
            clip_flag_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    apcm_pkg::REG_PRESENCE_LEVEL:   presence_reg   <= cfg_data[22:0];
                    apcm_pkg::REG_ON_DEBOUNCE:      on_deb_reg     <= cfg_data[DEB_W-1:0];
                    apcm_pkg::REG_OFF_DEBOUNCE:     off_deb_reg    <= cfg_data[DEB_W-1:0];
                    apcm_pkg::REG_CLIP_LEVEL:       clip_level_reg <= cfg_data[MAG_W-1:0];
                    apcm_pkg::REG_CLIP_CHUNK_LIMIT: clip_limit_reg <= cfg_data[CLIP_CNT_W-1:0];
                    default: ;
                endcase
            end
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            if (cmd.take_frame) begin
                last_reg <= s_chunk_end;
            end
            avg_reg       <= avg_next;
            playing_reg   <= playing_next;
            pending_reg   <= pending_next;
            change_reg    <= change_next;
            clip_cnt_reg  <= clip_cnt_next;
            clip_flag_reg <= clip_flag_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_frame) begin
            mag_reg   <= in_mag;
            pick_reg  <= (pos_reg != POS_W'(MAX_CHUNK_FRAMES)) && (phase_reg == '0);
            first_reg <= (pos_reg == '0);
        end
        if (cmd.frame_step) begin
            square_reg <= square_full[SQR_W-1:0];
        end
        rem_reg  <= rem_next;
        root_reg <= root_next;
        srem_reg <= srem_next;
        if (cmd.ema_a) begin
            prod_a_reg <= PROD_W'(apcm_pkg::ALPHA_Q16) * PROD_W'(rms_q8);
        end
        if (cmd.ema_b) begin
            prod_b_reg <= PROD_W'(apcm_pkg::KEEP_Q16) * PROD_W'(avg_reg);
        end
        if (cmd.load_out) begin
            m_playing        <= playing_reg;
            m_clipping       <= clip_flag_reg;
            m_smoothed_level <= avg_reg;
        end
    end

    a_clip_count_only_on_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$past(cmd.frame_step) |-> $stable(clip_cnt_reg))
        else $error("clip counter moved outside a frame step");

    a_playing_only_on_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$past(cmd.decide) |-> $stable(playing_reg))
        else $error("playing flag moved outside a decision step");

    a_change_cleared_on_switch: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (playing_reg != $past(playing_reg)) |-> (change_reg == '0))
        else $error("debounce count not cleared when playing state switched");

endmodule

// File: rtl/apcm_ctrl.sv
`timescale 1ns / 1ps

module apcm_ctrl #(
    parameter int SUM_W = apcm_pkg::SUM_W_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  apcm_pkg::status_t  status,
    output apcm_pkg::cmd_t     cmd
);

    localparam int ROOT_W = SUM_W / 2;
    localparam int STEP_W = $clog2(SUM_W);

    apcm_pkg::state_t  state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == apcm_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            apcm_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd.take_frame = 1'b1;
                    state_next     = apcm_pkg::ST_FRAME;
                end
            end
            apcm_pkg::ST_FRAME: begin
                cmd.frame_step = 1'b1;
                state_next     = apcm_pkg::ST_ACCUM;
            end
            apcm_pkg::ST_ACCUM: begin
                cmd.accum = 1'b1;
                if (status.last) begin
                    cmd.div_init = 1'b1;
                    step_next    = '0;
                    state_next   = apcm_pkg::ST_DIV;
                end else begin
                    state_next = apcm_pkg::ST_IDLE;
                end
            end
            apcm_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    step_next  = '0;
                    state_next = apcm_pkg::ST_SQRT;
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            apcm_pkg::ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (step_reg == STEP_W'(ROOT_W - 1)) begin
                    step_next  = '0;
                    state_next = apcm_pkg::ST_EMA_A;
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            apcm_pkg::ST_EMA_A: begin
                cmd.ema_a  = 1'b1;
                state_next = apcm_pkg::ST_EMA_B;
            end
            apcm_pkg::ST_EMA_B: begin
                cmd.ema_b  = 1'b1;
                state_next = apcm_pkg::ST_EMA_SUM;
            end
            apcm_pkg::ST_EMA_SUM: begin
                cmd.ema_sum = 1'b1;
                state_next  = apcm_pkg::ST_DECIDE;
            end
            apcm_pkg::ST_DECIDE: begin
                cmd.decide      = 1'b1;
                cmd.chunk_clear = 1'b1;
                state_next      = apcm_pkg::ST_EMIT;
            end
            apcm_pkg::ST_EMIT: begin
                // The status request waits here until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = apcm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = apcm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= apcm_pkg::ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten while still holding a request");

    a_valid_rises_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $rose(m_valid_reg) |-> $past(state_reg == apcm_pkg::ST_EMIT))
        else $error("result valid raised outside the emit state");

    a_div_only_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (state_reg == apcm_pkg::ST_DIV)
            && $past(state_reg == apcm_pkg::ST_ACCUM) |-> $past(status.last))
        else $error("chunk finish started on a frame that did not end the chunk");

endmodule

// File: tb/audio_presence_and_clip_monitor_core_test.sv
`timescale 1ns / 1ps

module audio_presence_and_clip_monitor_core_test;
    import apcm_pkg::*;

    localparam int CHUNK_CAP     = MAX_CHUNK_FRAMES_DEF;
    localparam int PICK_GAP      = PICK_STRIDE_DEF;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int MAX_REPORTS   = 10;
    localparam int REG_COUNT     = 5;

    localparam longint unsigned EMA_GAIN  = 3277;
    localparam longint unsigned EMA_KEEP  = 62259;
    localparam longint unsigned EMA_ROUND = 32768;
    localparam longint unsigned LEVEL_CAP = 64'h7FFF_FFFF;
    localparam longint unsigned ENTER_AVG_MUL = 20;
    localparam longint unsigned ENTER_LVL_MUL = 6912;
    localparam longint unsigned EXIT_AVG_MUL  = 4;
    localparam longint unsigned EXIT_LVL_MUL  = 768;
    localparam int CLIP_RUN_MAX = 65535;
    localparam int STREAK_MAX   = 1023;

    localparam logic [MAG_W-1:0] FULL_POS = 24'h7FFFFF;
    localparam logic [MAG_W-1:0] FULL_NEG = 24'h800000;

    typedef enum int {QUIET, MODERATE, LOUD} loudness_t;

    typedef struct packed {
        logic               playing;
        logic               clipping;
        logic [LEVEL_W-1:0] level;
    } chunk_status_t;

    typedef struct packed {
        logic [MAG_W-1:0] left;
        logic             chunk_end;
        logic             pinned;
        chunk_status_t    want;
    } frame_row_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [MAG_W-1:0] s_left_sample = '0;
    logic s_chunk_end = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_playing;
    logic m_clipping;
    logic [LEVEL_W-1:0] m_smoothed_level;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copy of the configuration registers, loaded with reset values.
    logic [22:0]           reg_presence   = 23'd838;
    logic [DEB_W-1:0]      reg_on_chunks  = 10'd120;
    logic [DEB_W-1:0]      reg_off_chunks = 10'd100;
    logic [MAG_W-1:0]      reg_clip_level = 24'd8388000;
    logic [CLIP_CNT_W-1:0] reg_clip_limit = 16'd25;

    // Predicted monitor state.
    int               frame_pos    = 0;
    longint unsigned  sq_acc       = 0;
    int               pick_cnt     = 0;
    logic [LEVEL_W-1:0] level_q8   = '0;
    logic             pred_playing = 1'b0;
    logic             cand_pending = 1'b0;
    int               streak       = 0;
    int               clip_run     = 0;
    logic             clip_hold    = 1'b0;

    chunk_status_t status_due_q[$];
    int        fail_count   = 0;
    int        report_count = 0;
    int        src_idle_pct = 0;
    int        sink_stall_pct = 0;
    logic      hold_request = 1'b0;
    logic      hold_taken   = 1'b0;
    int        hold_left    = 0;
    int        stall_cycles = 0;
    loudness_t cur_loud     = QUIET;

    frame_row_t directed_rows [21] = '{
        '{24'h000000, 1'b1, 1'b1, '{1'b0, 1'b0, 31'd0}},
        '{24'h000000, 1'b1, 1'b1, '{1'b0, 1'b0, 31'd0}},
        '{24'h7FFFFF, 1'b1, 1'b0, '0},
        '{24'h800000, 1'b1, 1'b0, '0},
        '{24'hFFFFFF, 1'b1, 1'b0, '0},
        '{24'h000001, 1'b1, 1'b0, '0},
        '{24'hFFF000, 1'b0, 1'b0, '0},
        '{24'h7FFFFF, 1'b0, 1'b0, '0},
        '{24'h7FFFFF, 1'b0, 1'b0, '0},
        '{24'h7FFFFF, 1'b0, 1'b0, '0},
        '{24'h7FFFFF, 1'b0, 1'b0, '0},
        '{24'h7FFFFF, 1'b0, 1'b0, '0},
        '{24'h7FFFFF, 1'b0, 1'b0, '0},
        '{24'h7FFFFF, 1'b0, 1'b0, '0},
        '{24'h001000, 1'b1, 1'b0, '0},
        '{24'h400000, 1'b0, 1'b0, '0},
        '{24'hC00000, 1'b1, 1'b0, '0},
        '{24'h800000, 1'b1, 1'b0, '0},
        '{24'h800000, 1'b1, 1'b0, '0},
        '{24'h800000, 1'b1, 1'b0, '0},
        '{24'h000000, 1'b1, 1'b0, '0}
    };

    audio_presence_and_clip_monitor_core u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_left_sample    (s_left_sample),
        .s_chunk_end      (s_chunk_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_playing        (m_playing),
        .m_clipping       (m_clipping),
        .m_smoothed_level (m_smoothed_level),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    // Advances the predicted state by one frame; returns 1 when the frame closes a chunk.
    function automatic logic track_frame(input logic [MAG_W-1:0] left, input logic chunk_end,
                                         output chunk_status_t status);
        logic [MAG_W-1:0] mag;
        longint unsigned  rms;
        longint unsigned  acc;
        longint unsigned  lvl;
        logic             want_on;
        int               need;
        mag = left[MAG_W-1] ? MAG_W'(~left + 24'd1) : left;
        status = '0;

        // Only the first frame of a chunk feeds the leaky clip counter.
        if (frame_pos == 0) begin
            if (mag > reg_clip_level) begin
                if (clip_run < CLIP_RUN_MAX) clip_run++;
            end else if (clip_run > 0) begin
                clip_run--;
            end
            if (clip_run > int'(reg_clip_limit)) clip_hold = 1'b1;
            else if (clip_run == 0) clip_hold = 1'b0;
        end

        if (frame_pos < CHUNK_CAP && frame_pos % PICK_GAP == 0) begin
            sq_acc += 64'(mag) * 64'(mag);
            pick_cnt++;
        end
        if (frame_pos < CHUNK_CAP) frame_pos++;
        if (!chunk_end) return 1'b0;

        rms = floor_root(sq_acc / 64'(pick_cnt));
        acc = (EMA_GAIN * (rms << 8) + EMA_KEEP * 64'(level_q8) + EMA_ROUND) >> 16;
        level_q8 = (acc > LEVEL_CAP) ? LEVEL_CAP[LEVEL_W-1:0] : acc[LEVEL_W-1:0];

        lvl = 64'(reg_presence);
        want_on = pred_playing ? (64'(level_q8) * EXIT_AVG_MUL > lvl * EXIT_LVL_MUL)
                               : (64'(level_q8) * ENTER_AVG_MUL > lvl * ENTER_LVL_MUL);
        if (want_on == pred_playing) begin
            streak = 0;
            cand_pending = pred_playing;
        end else begin
            if (cand_pending != want_on) begin
                cand_pending = want_on;
                streak = 1;
            end else if (streak < STREAK_MAX) begin
                streak++;
            end
            need = want_on ? int'(reg_on_chunks) : int'(reg_off_chunks);
            if (streak >= need) begin
                pred_playing = want_on;
                streak = 0;
            end
        end

        status.playing  = pred_playing;
        status.clipping = clip_hold;
        status.level    = level_q8;
        frame_pos = 0;
        sq_acc = 0;
        pick_cnt = 0;
        return 1'b1;
    endfunction

    function automatic logic [MAG_W-1:0] draw_sample(input loudness_t loud);
        logic [MAG_W-1:0] v;
        case (loud)
            QUIET:    v = MAG_W'($urandom_range(16)) - 24'd8;
            MODERATE: v = MAG_W'($urandom_range(8191)) - 24'd4096;
            default:  v = MAG_W'($urandom);
        endcase
        if ($urandom_range(19) == 0) v = $urandom_range(1) ? FULL_POS : FULL_NEG;
        return v;
    endfunction

    // Valid is left high after a request is taken; it drops only before an idle gap
    // or when a phase winds down.
    task automatic push_frame(input logic [MAG_W-1:0] left, input logic chunk_end,
                              input logic pinned, input chunk_status_t want);
        chunk_status_t status;
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid <= 1'b1;
        s_left_sample <= left;
        s_chunk_end <= chunk_end;
        do @(posedge aclk); while (!s_ready);
        if (track_frame(left, chunk_end, status))
            status_due_q.push_back(pinned ? want : status);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_PRESENCE_LEVEL:   reg_presence   = val[22:0];
            REG_ON_DEBOUNCE:      reg_on_chunks  = val[DEB_W-1:0];
            REG_OFF_DEBOUNCE:     reg_off_chunks = val[DEB_W-1:0];
            REG_CLIP_LEVEL:       reg_clip_level = val[MAG_W-1:0];
            REG_CLIP_CHUNK_LIMIT: reg_clip_limit = val[CLIP_CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] presence, on_chunks, off_chunks,
                             clip_lvl, clip_lim);
        write_reg(REG_PRESENCE_LEVEL, presence);
        write_reg(REG_ON_DEBOUNCE, on_chunks);
        write_reg(REG_OFF_DEBOUNCE, off_chunks);
        write_reg(REG_CLIP_LEVEL, clip_lvl);
        write_reg(REG_CLIP_CHUNK_LIMIT, clip_lim);
        // A write past the register list must leave every register alone.
        write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, (1 << CFG_IDX_W) - 1)),
                  CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic configure_random();
        configure(CFG_DATA_W'($urandom_range(20000)), CFG_DATA_W'($urandom_range(1, 3)),
                  CFG_DATA_W'($urandom_range(1, 3)),
                  CFG_DATA_W'($urandom_range(4000000, 8388000)),
                  CFG_DATA_W'($urandom_range(3)));
    endtask

    task automatic set_idling(input int src_pct, input int sink_pct);
        src_idle_pct = src_pct;
        sink_stall_pct <= sink_pct;
    endtask

    task automatic send_chunk(input int len);
        for (int k = 0; k < len; k++)
            push_frame(draw_sample(cur_loud), k == len - 1, 1'b0, '0);
    endtask

    task automatic random_traffic(input int frame_goal);
        int sent;
        int len;
        sent = 0;
        while (sent < frame_goal) begin
            // Loudness tends to persist so the average has time to cross the thresholds.
            if ($urandom_range(4) == 0) cur_loud = loudness_t'($urandom_range(2));
            case ($urandom_range(9))
                0, 1, 2, 3, 4: len = $urandom_range(1, 3);
                5, 6, 7, 8:    len = $urandom_range(4, 17);
                default:       len = $urandom_range(18, 40);
            endcase
            send_chunk(len);
            sent += len;
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (status_due_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Result side: random back-pressure, one long hold on request, and the checker.
    always @(posedge aclk) begin
        chunk_status_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (status_due_q.size() == 0) begin
                    fail_count++;
                    if (report_count < MAX_REPORTS)
                        $display("unexpected status: playing=%0d clipping=%0d level=%0d",
                                 m_playing, m_clipping, m_smoothed_level);
                    report_count++;
                end else begin
                    want = status_due_q.pop_front();
                    if (m_playing !== want.playing || m_clipping !== want.clipping ||
                        m_smoothed_level !== want.level) begin
                        fail_count++;
                        if (report_count < MAX_REPORTS)
                            $display("mismatch: want p=%0d c=%0d lvl=%0d, got p=%0d c=%0d lvl=%0d",
                                     want.playing, want.clipping, want.level,
                                     m_playing, m_clipping, m_smoothed_level);
                        report_count++;
                    end
                end
            end
            if (!hold_request) hold_taken <= 1'b0;
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else if (hold_request && !hold_taken) begin
                hold_left <= HOLD_CYCLES;
                hold_taken <= 1'b1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= $urandom_range(99) >= sink_stall_pct;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles + 1 >= STALL_LIMIT) begin
                $display("no request moved for %0d cycles", STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frames run on the reset configuration.
        foreach (directed_rows[i])
            push_frame(directed_rows[i].left, directed_rows[i].chunk_end,
                       directed_rows[i].pinned, directed_rows[i].want);
        settle();

        // Zero thresholds and zero debounce: any change is taken at once.
        configure(24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
        cur_loud = LOUD;
        send_chunk(CHUNK_CAP + 14);
        random_traffic(20);
        settle();

        // Upper extremes; the presence write carries a bit above the register width.
        set_idling(70, 0);
        configure(24'hFFFFFF, 24'd1023, 24'd1023, 24'h800000, 24'd65535);
        random_traffic(20);
        settle();

        set_idling(0, 70);
        configure_random();
        random_traffic(20);
        settle();

        // Hold the result side off while chunk ends keep arriving.
        set_idling(0, 0);
        configure_random();
        hold_request <= 1'b1;
        cur_loud = LOUD;
        for (int k = 0; k < 20; k++) push_frame(draw_sample(cur_loud), 1'b1, 1'b0, '0);
        hold_request <= 1'b0;
        settle();

        set_idling(6, 6);
        configure_random();
        random_traffic(20);
        settle();

        set_idling(0, 0);
        configure(24'd1, 24'd1, 24'd1, 24'd8388607, 24'd1);
        random_traffic(20);
        settle();

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/apcm_pkg.sv
rtl/apcm_dp.sv
rtl/apcm_ctrl.sv
rtl/audio_presence_and_clip_monitor_core.sv
tb/audio_presence_and_clip_monitor_core_test.sv
